// ===== rtl/chm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the cuckoo hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
    localparam int unsigned MIX_SH1  = 30;
    localparam int unsigned MIX_SH2  = 27;
    localparam int unsigned MIX_SH3  = 31;
    localparam logic [63:0] EMPTY_KEY = 64'hffff_ffff_ffff_ffff;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_ERASE  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_REJECT   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        HS_IDLE,
        HS_MIX1,
        HS_M1A,
        HS_M1B,
        HS_M1C,
        HS_MIX2,
        HS_M2A,
        HS_M2B,
        HS_M2C,
        HS_FIN
    } hash_state_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_HASH,
        ST_RDA,
        ST_RDB,
        ST_CHK,
        ST_PLACE,
        ST_KHASH,
        ST_KRD,
        ST_KWAIT
    } map_state_t;

endpackage
`default_nettype wire

// ===== rtl/cuckoo_hash_map.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cuckoo_hash_map
// Single-table cuckoo hash map with lookup, set, erase and clear.
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and exactly one
// result follows with done high for a single cycle; the result cannot be held
// off. Lookup, erase and update run a hash on one shared 32x32 multiplier
// plus two slot reads from the single-port-read memory. A new key adds a
// rehash and a slot read per eviction, up to MAX_KICKS evictions. A clear
// writes one slot per cycle over all 2^TABLE_LOG_SIZE slots; after reset the
// same clearing pass runs (busy high). A reserved-key request answers the
// next cycle.
// ----------------------------------------------------------------------------
module cuckoo_hash_map #(
    parameter int unsigned TABLE_LOG_SIZE = 10,
    parameter int unsigned VALUE_BITS     = 32,
    parameter int unsigned MAX_KICKS      = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [63:0] key,
    input  wire logic [31:0] value,
    output logic             done,
    output logic             found,
    output logic      [31:0] read_value,
    output logic      [1:0]  status,
    output logic      [63:0] dropped_key,
    output logic      [31:0] dropped_value
);

    localparam int unsigned L   = TABLE_LOG_SIZE;
    localparam int unsigned VB  = VALUE_BITS;
    localparam int unsigned EW  = 64 + VB;
    localparam int unsigned KCW = $clog2(MAX_KICKS + 1);
    localparam logic [KCW-1:0] KICK_LAST = KCW'(MAX_KICKS - 1);

    chm_pkg::map_state_t state_reg, state_next;
    logic [1:0]    func_reg, func_next;
    logic [63:0]   key_reg, key_next;
    logic [VB-1:0] val_reg, val_next;
    logic [L-1:0]  a_reg, a_next, b_reg, b_next, pos_reg, pos_next;
    logic [63:0]   enta_key_reg, enta_key_next;
    logic [VB-1:0] enta_val_reg, enta_val_next;
    logic [63:0]   cur_key_reg, cur_key_next;
    logic [VB-1:0] cur_val_reg, cur_val_next;
    logic [63:0]   occ_key_reg, occ_key_next;
    logic [VB-1:0] occ_val_reg, occ_val_next;
    logic [KCW-1:0] kick_reg, kick_next;
    logic [L-1:0]  clr_cnt_reg, clr_cnt_next;
    logic          clr_resp_reg, clr_resp_next;
    logic [63:0]   seed_reg;
    logic          done_reg, done_next;
    logic          found_reg, found_next;
    logic [31:0]   rval_reg, rval_next;
    logic [1:0]    status_reg, status_next;
    logic [63:0]   dkey_reg, dkey_next;
    logic [31:0]   dval_reg, dval_next;

    logic          h_start, h_done;
    logic [63:0]   h_key, h_out;
    logic          we;
    logic [L-1:0]  waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [63:0]   rd_key;
    logic [VB-1:0] rd_val;
    logic [95:0]   val_wide;
    logic [VB+31:0] hit_wide, drop_wide;
    logic          hit_a, hit_b, hit_any;
    logic [L-1:0]  hit_addr;
    logic [VB-1:0] hit_val;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? 64'd0 : seed_reg;
    assign busy   = (state_reg != chm_pkg::ST_IDLE);
    assign done          = done_reg;
    assign found         = found_reg;
    assign read_value    = rval_reg;
    assign status        = status_reg;
    assign dropped_key   = dkey_reg;
    assign dropped_value = dval_reg;

    assign rd_key   = rdata[EW-1:VB];
    assign rd_val   = rdata[VB-1:0];
    assign val_wide = {64'd0, value};
    assign hit_a    = (enta_key_reg == key_reg);
    assign hit_b    = (rd_key == key_reg);
    assign hit_any  = hit_a | hit_b;
    assign hit_addr = hit_a ? a_reg : b_reg;
    assign hit_val  = hit_a ? enta_val_reg : rd_val;
    assign hit_wide  = {32'd0, hit_val};
    assign drop_wide = {32'd0, occ_val_reg};
    assign h_key    = (state_reg == chm_pkg::ST_IDLE) ? key : occ_key_reg;

    chm_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (h_start),
        .key   (h_key),
        .seed  (seed_reg),
        .done  (h_done),
        .hash  (h_out)
    );

    chm_store #(
        .ADDR_BITS (L),
        .DATA_BITS (EW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 64'd0;
        end
        else if (psel && penable && pwrite && !paddr[3])
        begin
            seed_reg <= pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= chm_pkg::ST_CLR;
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            done_reg     <= 1'b0;
            kick_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            done_reg     <= done_next;
            kick_reg     <= kick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        pos_reg      <= pos_next;
        enta_key_reg <= enta_key_next;
        enta_val_reg <= enta_val_next;
        cur_key_reg  <= cur_key_next;
        cur_val_reg  <= cur_val_next;
        occ_key_reg  <= occ_key_next;
        occ_val_reg  <= occ_val_next;
        found_reg    <= found_next;
        rval_reg     <= rval_next;
        status_reg   <= status_next;
        dkey_reg     <= dkey_next;
        dval_reg     <= dval_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        pos_next      = pos_reg;
        enta_key_next = enta_key_reg;
        enta_val_next = enta_val_reg;
        cur_key_next  = cur_key_reg;
        cur_val_next  = cur_val_reg;
        occ_key_next  = occ_key_reg;
        occ_val_next  = occ_val_reg;
        kick_next     = kick_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_resp_next = clr_resp_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        rval_next     = rval_reg;
        status_next   = status_reg;
        dkey_next     = dkey_reg;
        dval_next     = dval_reg;
        h_start       = 1'b0;
        we            = 1'b0;
        waddr         = pos_reg;
        wdata         = {cur_key_reg, cur_val_reg};
        raddr         = a_reg;
        case (state_reg)
            chm_pkg::ST_CLR:
            begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
                wdata = {chm_pkg::EMPTY_KEY, {VB{1'b0}}};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next    = chm_pkg::ST_IDLE;
                    clr_resp_next = 1'b0;
                    if (clr_resp_reg)
                    begin
                        done_next   = 1'b1;
                        found_next  = 1'b0;
                        rval_next   = 32'd0;
                        status_next = chm_pkg::STAT_OK;
                        dkey_next   = 64'd0;
                        dval_next   = 32'd0;
                    end
                end
            end
            chm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    key_next  = key;
                    val_next  = val_wide[VB-1:0];
                    if (func == chm_pkg::FUNC_CLEAR)
                    begin
                        clr_cnt_next  = '0;
                        clr_resp_next = 1'b1;
                        state_next    = chm_pkg::ST_CLR;
                    end
                    else if (key == chm_pkg::EMPTY_KEY)
                    begin
                        done_next   = 1'b1;
                        found_next  = 1'b0;
                        rval_next   = 32'd0;
                        status_next = chm_pkg::STAT_REJECT;
                        dkey_next   = 64'd0;
                        dval_next   = 32'd0;
                    end
                    else
                    begin
                        h_start    = 1'b1;
                        state_next = chm_pkg::ST_HASH;
                    end
                end
            end
            chm_pkg::ST_HASH:
            begin
                if (h_done)
                begin
                    a_next     = h_out[L-1:0];
                    b_next     = h_out[L-1:0] ^ h_out[2*L-1:L];
                    state_next = chm_pkg::ST_RDA;
                end
            end
            chm_pkg::ST_RDA:
            begin
                raddr      = a_reg;
                state_next = chm_pkg::ST_RDB;
            end
            chm_pkg::ST_RDB:
            begin
                raddr         = b_reg;
                enta_key_next = rd_key;
                enta_val_next = rd_val;
                state_next    = chm_pkg::ST_CHK;
            end
            chm_pkg::ST_CHK:
            begin
                found_next  = hit_any;
                rval_next   = 32'd0;
                status_next = chm_pkg::STAT_OK;
                dkey_next   = 64'd0;
                dval_next   = 32'd0;
                waddr       = hit_addr;
                state_next  = chm_pkg::ST_IDLE;
                done_next   = 1'b1;
                case (func_reg)
                    chm_pkg::FUNC_LOOKUP:
                    begin
                        if (hit_any)
                        begin
                            rval_next = hit_wide[31:0];
                        end
                    end
                    chm_pkg::FUNC_ERASE:
                    begin
                        we    = hit_any;
                        wdata = {chm_pkg::EMPTY_KEY, {VB{1'b0}}};
                    end
                    chm_pkg::FUNC_SET:
                    begin
                        if (hit_any)
                        begin
                            we    = 1'b1;
                            wdata = {key_reg, val_reg};
                        end
                        else
                        begin
                            done_next    = 1'b0;
                            cur_key_next = key_reg;
                            cur_val_next = val_reg;
                            occ_key_next = enta_key_reg;
                            occ_val_next = enta_val_reg;
                            pos_next     = a_reg;
                            kick_next    = '0;
                            state_next   = chm_pkg::ST_PLACE;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            chm_pkg::ST_PLACE:
            begin
                we    = 1'b1;
                waddr = pos_reg;
                wdata = {cur_key_reg, cur_val_reg};
                if (occ_key_reg == chm_pkg::EMPTY_KEY)
                begin
                    done_next  = 1'b1;
                    state_next = chm_pkg::ST_IDLE;
                end
                else
                begin
                    cur_key_next = occ_key_reg;
                    cur_val_next = occ_val_reg;
                    if (kick_reg == KICK_LAST)
                    begin
                        done_next   = 1'b1;
                        status_next = chm_pkg::STAT_OVERFLOW;
                        dkey_next   = occ_key_reg;
                        dval_next   = drop_wide[31:0];
                        state_next  = chm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        kick_next  = kick_reg + 1'b1;
                        h_start    = 1'b1;
                        state_next = chm_pkg::ST_KHASH;
                    end
                end
            end
            chm_pkg::ST_KHASH:
            begin
                if (h_done)
                begin
                    pos_next   = pos_reg ^ h_out[2*L-1:L];
                    state_next = chm_pkg::ST_KRD;
                end
            end
            chm_pkg::ST_KRD:
            begin
                raddr      = pos_reg;
                state_next = chm_pkg::ST_KWAIT;
            end
            chm_pkg::ST_KWAIT:
            begin
                occ_key_next = rd_key;
                occ_val_next = rd_val;
                state_next   = chm_pkg::ST_PLACE;
            end
            default:
            begin
                state_next = chm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/chm_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chm_hash
// Multi-cycle 64-bit mix finalizer; each 64x64 product is built from three
// 32x32 partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module chm_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] key,
    input  wire logic [63:0] seed,
    output logic             done,
    output logic [63:0]      hash
);

    chm_pkg::hash_state_t state_reg, state_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] hash_reg, hash_next;
    logic        done_reg, done_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    assign prod = mul_a * mul_b;
    assign done = done_reg;
    assign hash = hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::HS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        hash_reg <= hash_next;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        hash_next  = hash_reg;
        done_next  = 1'b0;
        mul_a      = x_reg[31:0];
        mul_b      = chm_pkg::MIX_MUL1[31:0];
        case (state_reg)
            chm_pkg::HS_IDLE:
            begin
                if (start)
                begin
                    x_next     = key + chm_pkg::MIX_ADD;
                    state_next = chm_pkg::HS_MIX1;
                end
            end
            chm_pkg::HS_MIX1:
            begin
                x_next     = x_reg ^ (x_reg >> chm_pkg::MIX_SH1);
                state_next = chm_pkg::HS_M1A;
            end
            chm_pkg::HS_M1A:
            begin
                acc_next   = prod;
                state_next = chm_pkg::HS_M1B;
            end
            chm_pkg::HS_M1B:
            begin
                mul_b             = chm_pkg::MIX_MUL1[63:32];
                acc_next[63:32]   = acc_reg[63:32] + prod[31:0];
                state_next        = chm_pkg::HS_M1C;
            end
            chm_pkg::HS_M1C:
            begin
                mul_a             = x_reg[63:32];
                acc_next[63:32]   = acc_reg[63:32] + prod[31:0];
                state_next        = chm_pkg::HS_MIX2;
            end
            chm_pkg::HS_MIX2:
            begin
                x_next     = acc_reg ^ (acc_reg >> chm_pkg::MIX_SH2);
                state_next = chm_pkg::HS_M2A;
            end
            chm_pkg::HS_M2A:
            begin
                mul_b      = chm_pkg::MIX_MUL2[31:0];
                acc_next   = prod;
                state_next = chm_pkg::HS_M2B;
            end
            chm_pkg::HS_M2B:
            begin
                mul_b             = chm_pkg::MIX_MUL2[63:32];
                acc_next[63:32]   = acc_reg[63:32] + prod[31:0];
                state_next        = chm_pkg::HS_M2C;
            end
            chm_pkg::HS_M2C:
            begin
                mul_a             = x_reg[63:32];
                mul_b             = chm_pkg::MIX_MUL2[31:0];
                acc_next[63:32]   = acc_reg[63:32] + prod[31:0];
                state_next        = chm_pkg::HS_FIN;
            end
            chm_pkg::HS_FIN:
            begin
                hash_next  = acc_reg ^ (acc_reg >> chm_pkg::MIX_SH3) ^ seed;
                done_next  = 1'b1;
                state_next = chm_pkg::HS_IDLE;
            end
            default:
            begin
                state_next = chm_pkg::HS_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/chm_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chm_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chm_store #(
    parameter int unsigned ADDR_BITS = 10,
    parameter int unsigned DATA_BITS = 96
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the cuckoo hash map.
// A queue of pending requests feeds a clocked driver. Each accepted request
// updates a local copy of the table and its predicted response is queued;
// a clocked monitor compares every done strobe with the oldest prediction.
// Phases run under several seeds: directed corner requests, mixed random
// traffic, and a long fill that pushes the table into insert overflows.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned SLOT_BITS = 10;
    localparam int unsigned SLOTS     = 1 << SLOT_BITS;
    localparam logic [3:0]  ADDR_HASH_SEED = 4'h0;

    typedef struct {
        chm_pkg::func_t fn;
        logic [63:0]    k;
        logic [31:0]    v;
    } request_t;

    typedef struct {
        logic             hit;
        logic [31:0]      rd;
        chm_pkg::status_t st;
        logic [63:0]      dk;
        logic [31:0]      dv;
    } response_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  func = '0;
    logic [63:0] key = '0;
    logic [31:0] value = '0;
    logic        done;
    logic        found;
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [63:0] dropped_key;
    logic [31:0] dropped_value;

    cuckoo_hash_map dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .func(func), .key(key), .value(value),
        .done(done), .found(found), .read_value(read_value), .status(status),
        .dropped_key(dropped_key), .dropped_value(dropped_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    request_t    pending_q[$];
    response_t   response_q[$];
    logic [63:0] live_keys[$];
    logic [63:0] tbl_key[SLOTS];
    logic [31:0] tbl_val[SLOTS];
    logic [63:0] seed_copy = '0;
    int          errors = 0;
    int          gap_left = 0;
    request_t    cur;

    function automatic logic [63:0] mix(input logic [63:0] k, input logic [63:0] s);
        logic [63:0] x;
        x = k + chm_pkg::MIX_ADD;
        x = (x ^ (x >> chm_pkg::MIX_SH1)) * chm_pkg::MIX_MUL1;
        x = (x ^ (x >> chm_pkg::MIX_SH2)) * chm_pkg::MIX_MUL2;
        return x ^ (x >> chm_pkg::MIX_SH3) ^ s;
    endfunction

    function automatic logic [SLOT_BITS-1:0] hop(input logic [63:0] h);
        return h[2*SLOT_BITS-1:SLOT_BITS];
    endfunction

    function void wipe_table();
        for (int n = 0; n < SLOTS; n++)
        begin
            tbl_key[n] = chm_pkg::EMPTY_KEY;
            tbl_val[n] = '0;
        end
    endfunction

    function response_t apply_request(input request_t r);
        response_t             rsp;
        logic [63:0]           h, ck, ok;
        logic [31:0]           cv, ov;
        logic [SLOT_BITS-1:0]  a, b, pos, at;
        int                    kicks;
        rsp = '{1'b0, '0, chm_pkg::STAT_OK, '0, '0};
        if (r.fn == chm_pkg::FUNC_CLEAR)
            wipe_table();
        else if (r.k == chm_pkg::EMPTY_KEY)
            rsp.st = chm_pkg::STAT_REJECT;
        else
        begin
            h = mix(r.k, seed_copy);
            a = h[SLOT_BITS-1:0];
            b = a ^ hop(h);
            if (tbl_key[a] == r.k)
            begin
                rsp.hit = 1'b1;
                at = a;
            end
            else if (tbl_key[b] == r.k)
            begin
                rsp.hit = 1'b1;
                at = b;
            end
            if (r.fn == chm_pkg::FUNC_LOOKUP)
            begin
                if (rsp.hit)
                    rsp.rd = tbl_val[at];
            end
            else if (r.fn == chm_pkg::FUNC_ERASE)
            begin
                if (rsp.hit)
                begin
                    tbl_key[at] = chm_pkg::EMPTY_KEY;
                    tbl_val[at] = '0;
                end
            end
            else if (rsp.hit)
                tbl_val[at] = r.v;
            else
            begin
                ck = r.k;
                cv = r.v;
                pos = a;
                kicks = 0;
                forever
                begin
                    ok = tbl_key[pos];
                    ov = tbl_val[pos];
                    tbl_key[pos] = ck;
                    tbl_val[pos] = cv;
                    if (ok == chm_pkg::EMPTY_KEY)
                        break;
                    ck = ok;
                    cv = ov;
                    kicks++;
                    if (kicks >= 32)
                    begin
                        rsp.st = chm_pkg::STAT_OVERFLOW;
                        rsp.dk = ck;
                        rsp.dv = cv;
                        break;
                    end
                    pos = pos ^ hop(mix(ck, seed_copy));
                end
            end
        end
        return rsp;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                response_q.push_back(apply_request(cur));
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur = pending_q.pop_front();
                    start <= 1'b1;
                    func <= cur.fn;
                    key <= cur.k;
                    value <= cur.v;
                    gap_left = pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        response_t e;
        if (done)
        begin
            if (response_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: response with no request outstanding");
            end
            else
            begin
                e = response_q.pop_front();
                if (found !== e.hit || read_value !== e.rd || status !== e.st
                    || dropped_key !== e.dk || dropped_value !== e.dv)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: exp %0b %h %0d %h %h, got %0b %h %0d %h %h",
                                 e.hit, e.rd, e.st, e.dk, e.dv, found, read_value,
                                 status, dropped_key, dropped_value);
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function void add(input chm_pkg::func_t fn, input logic [63:0] k, input logic [31:0] v);
        pending_q.push_back('{fn, k, v});
        if (fn == chm_pkg::FUNC_SET && k != chm_pkg::EMPTY_KEY)
            live_keys.push_back(k);
        if (fn == chm_pkg::FUNC_CLEAR)
            live_keys.delete();
    endfunction

    function logic [63:0] old_key();
        if (live_keys.size() == 0 || $urandom_range(9) < 3)
            return rand64();
        return live_keys[$urandom_range(live_keys.size() - 1)];
    endfunction

    function void add_mixed(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                add(chm_pkg::func_t'($urandom_range(2)), chm_pkg::EMPTY_KEY, $urandom);
            else if (r < 5)
                add(chm_pkg::FUNC_CLEAR, rand64(), $urandom);
            else if (r < 45)
                add(chm_pkg::FUNC_SET, ($urandom_range(9) < 6) ? rand64() : old_key(),
                    $urandom);
            else if (r < 75)
                add(chm_pkg::FUNC_LOOKUP, old_key(), $urandom);
            else
                add(chm_pkg::FUNC_ERASE, old_key(), $urandom);
        end
    endfunction

    function void add_fill(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 85)
                add(chm_pkg::FUNC_SET, rand64(), $urandom);
            else if (r < 95)
                add(chm_pkg::FUNC_LOOKUP, old_key(), $urandom);
            else
                add(chm_pkg::FUNC_SET, old_key(), $urandom);
        end
    endfunction

    task automatic wait_idle();
        while (pending_q.size() > 0 || start || response_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_HASH_SEED;
        pwdata <= s;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        seed_copy = s;
    endtask

    initial
    begin
        logic [63:0] zk;
        wipe_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        add(chm_pkg::FUNC_LOOKUP, chm_pkg::EMPTY_KEY, 32'hffff_ffff);
        add(chm_pkg::FUNC_SET, chm_pkg::EMPTY_KEY, 32'hffff_ffff);
        add(chm_pkg::FUNC_ERASE, chm_pkg::EMPTY_KEY, '0);
        add(chm_pkg::FUNC_LOOKUP, 64'h0, '0);
        add(chm_pkg::FUNC_SET, 64'h0, '0);
        add(chm_pkg::FUNC_LOOKUP, 64'h0, '0);
        add(chm_pkg::FUNC_SET, 64'h0, 32'hffff_ffff);
        add(chm_pkg::FUNC_LOOKUP, 64'h0, '0);
        add(chm_pkg::FUNC_SET, 64'hffff_ffff_ffff_fffe, 32'h8000_0001);
        add(chm_pkg::FUNC_LOOKUP, 64'hffff_ffff_ffff_fffe, '0);
        add(chm_pkg::FUNC_ERASE, 64'h0, '0);
        add(chm_pkg::FUNC_ERASE, 64'h0, '0);
        add(chm_pkg::FUNC_LOOKUP, 64'h0, '0);
        do
            zk = rand64();
        while (hop(mix(zk, 64'h0)) != '0);
        add(chm_pkg::FUNC_SET, zk, $urandom);
        add(chm_pkg::FUNC_LOOKUP, zk, '0);
        add(chm_pkg::FUNC_ERASE, zk, '0);
        add(chm_pkg::FUNC_CLEAR, chm_pkg::EMPTY_KEY, 32'hffff_ffff);
        add(chm_pkg::FUNC_LOOKUP, 64'hffff_ffff_ffff_fffe, '0);
        add_mixed(150);
        wait_idle();

        write_seed(64'hffff_ffff_ffff_ffff);
        add(chm_pkg::FUNC_CLEAR, '0, '0);
        add_fill(560);
        wait_idle();

        write_seed(rand64());
        add_mixed(150);
        wait_idle();

        write_seed(64'h0);
        add_mixed(50);
        wait_idle();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(12 * 3000000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/chm_pkg.sv
rtl/chm_hash.sv
rtl/chm_store.sv
rtl/cuckoo_hash_map.sv
tb/sv/tb_top.sv
